// File: rtl/kfar_pkg.sv
// shared types, constants and saturation helpers for the angle/rate kalman filter
`default_nettype none

package kfar_pkg;

    // number format
    localparam int W    = 32;
    localparam int FB   = 24;
    localparam int WIDE = W + 2;
    localparam int CFG_W = 31;
    localparam int IDX_W = 3;

    // serial divider: two quotient bits per cycle
    localparam int DIV_STEPS = (W + FB + 1) / 2;
    localparam int DIV_N     = 2 * DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef logic signed [W-1:0]    word_t;
    typedef logic signed [WIDE-1:0] wide_t;
    typedef logic [CFG_W-1:0]       cfg_t;

    localparam word_t ONE_FX = word_t'(1) << FB;
    localparam word_t WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam wide_t WMAX_X = {3'b000, {(W-1){1'b1}}};
    localparam wide_t WMIN_X = {3'b111, {(W-1){1'b0}}};

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_STEP_TIME   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_ANGLE_NOISE = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RATE_NOISE  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MEAS_NOISE  = 3'd3;
    localparam logic [IDX_W-1:0] CFG_INIT_ANGLE  = 3'd4;

    // shared multiplier result
    typedef struct packed {
        word_t value;
        logic  ovf;
    } mul_res_t;

    // divider status
    typedef struct packed {
        logic  done;
        logic  ovf;
        word_t quo;
    } div_stat_t;

    function automatic wide_t ext_s(input word_t a);
        ext_s = {{2{a[W-1]}}, a};
    endfunction

    function automatic wide_t ext_u(input cfg_t a);
        ext_u = {3'b000, a};
    endfunction

    function automatic logic sat_ovf(input wide_t v);
        sat_ovf = (v > WMAX_X) || (v < WMIN_X);
    endfunction

    function automatic word_t sat_word(input wide_t v);
        if (v > WMAX_X)
            sat_word = WMAX;
        else if (v < WMIN_X)
            sat_word = WMIN;
        else
            sat_word = v[W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/kfar_mul.sv
// shared fixed-point multiplier: registered product, then round and saturate
`default_nettype none

module kfar_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire kfar_pkg::word_t   op_a,
    input  wire kfar_pkg::word_t   op_b,
    output kfar_pkg::mul_res_t     res
);

    localparam int PW = 2 * kfar_pkg::W;

    logic [kfar_pkg::W-1:0] mag_a;
    logic [kfar_pkg::W-1:0] mag_b;
    logic [PW-1:0]          prod_reg;
    logic [PW-1:0]          prod_next;
    logic                   neg_reg;
    logic                   neg_next;
    logic [PW-1:0]          rounded;
    logic [PW-1:0]          lim;
    logic [PW-1:0]          clamped;
    logic                   over;

    // magnitude product
    always_comb
    begin
        mag_a     = op_a[kfar_pkg::W-1] ? kfar_pkg::W'(-op_a) : kfar_pkg::W'(op_a);
        mag_b     = op_b[kfar_pkg::W-1] ? kfar_pkg::W'(-op_b) : kfar_pkg::W'(op_b);
        prod_next = PW'(mag_a) * PW'(mag_b);
        neg_next  = op_a[kfar_pkg::W-1] ^ op_b[kfar_pkg::W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_reg <= '0;
            neg_reg  <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_next;
            neg_reg  <= neg_next;
        end
    end

    // round half away from zero, clamp to the word range
    always_comb
    begin
        rounded   = (prod_reg + (PW'(1) << (kfar_pkg::FB - 1))) >> kfar_pkg::FB;
        lim       = neg_reg ? (PW'(1) << (kfar_pkg::W - 1))
                            : ((PW'(1) << (kfar_pkg::W - 1)) - PW'(1));
        over      = rounded > lim;
        clamped   = over ? lim : rounded;
        res.ovf   = over;
        res.value = neg_reg ? kfar_pkg::word_t'(-clamped[kfar_pkg::W-1:0])
                            : kfar_pkg::word_t'(clamped[kfar_pkg::W-1:0]);
    end

endmodule

`default_nettype wire

// File: rtl/kfar_div.sv
// serial restoring divider for the gains, two bits per cycle, round to nearest
`default_nettype none

module kfar_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire kfar_pkg::word_t     num,
    input  wire logic [kfar_pkg::W:0] den,
    output kfar_pkg::div_stat_t      stat
);

    localparam int RW = kfar_pkg::W + 2;
    localparam int N  = kfar_pkg::DIV_N;

    logic                          busy_reg, busy_next;
    logic                          fin_reg, fin_next;
    logic [kfar_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [N-1:0]                  quo_reg, quo_next;
    logic [N-1:0]                  dvd_reg, dvd_next;
    logic [kfar_pkg::W:0]          den_reg, den_next;
    logic                          neg_reg, neg_next;
    kfar_pkg::div_stat_t           stat_reg, stat_next;

    logic [kfar_pkg::W-1:0] mag_n;
    logic [RW-1:0]          r1, r1s, r2, r2s;
    logic                   ge1, ge2;
    logic                   up;
    logic [N:0]             q1, lim, qc;
    logic                   over;

    always_comb
    begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        stat_next = stat_reg;
        stat_next.done = 1'b0;

        mag_n = num[kfar_pkg::W-1] ? kfar_pkg::W'(-num) : kfar_pkg::W'(num);

        // two restoring steps
        r1  = {rem_reg[RW-2:0], dvd_reg[N-1]};
        ge1 = r1 >= RW'(den_reg);
        r1s = ge1 ? r1 - RW'(den_reg) : r1;
        r2  = {r1s[RW-2:0], dvd_reg[N-2]};
        ge2 = r2 >= RW'(den_reg);
        r2s = ge2 ? r2 - RW'(den_reg) : r2;

        // final rounding and clamp
        up   = {rem_reg, 1'b0} >= (RW + 1)'(den_reg);
        q1   = (N + 1)'(quo_reg) + (N + 1)'(up);
        lim  = neg_reg ? ((N + 1)'(1) << (kfar_pkg::W - 1))
                       : (((N + 1)'(1) << (kfar_pkg::W - 1)) - (N + 1)'(1));
        over = q1 > lim;
        qc   = over ? lim : q1;

        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = '0;
            dvd_next  = N'(mag_n) << kfar_pkg::FB;
            den_next  = den;
            neg_next  = num[kfar_pkg::W-1];
        end
        else if (busy_reg)
        begin
            rem_next = r2s;
            quo_next = {quo_reg[N-3:0], ge1, ge2};
            dvd_next = dvd_reg << 2;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == kfar_pkg::DIV_CNT_W'(kfar_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end

        if (fin_reg)
        begin
            stat_next.done = 1'b1;
            stat_next.ovf  = over;
            stat_next.quo  = neg_reg ? kfar_pkg::word_t'(-qc[kfar_pkg::W-1:0])
                                     : kfar_pkg::word_t'(qc[kfar_pkg::W-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvd_reg  <= '0;
            den_reg  <= '0;
            neg_reg  <= 1'b0;
            stat_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvd_reg  <= dvd_next;
            den_reg  <= den_next;
            neg_reg  <= neg_next;
            stat_reg <= stat_next;
        end
    end

    assign stat = stat_reg;

endmodule

`default_nettype wire

// File: rtl/kalman_filter_angle_rate_top.sv
// two-state angle/rate kalman filter: sequencer, state, config and output stage
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_stall    op, measurement
//   out      out  out_valid/out_stall  angle_est, filtered_rate, saturated
//   cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// an update beat keeps in_stall high through ten passes through the shared multiplier (each a
// multiply state and a write-back state), a noise step, a gain check and two gain divisions
// (28 two-bit steps, rounding, status register each), then the finish step. with a non-positive
// denominator the divisions are skipped. a reinitialize beat goes straight to the finish step.
// the result is loaded at the edge that ends the stall and the next input beat can be taken in
// the cycle after, so a new update beat is taken only once the last one has finished.
// in_stall is high from accept until the result is loaded into the output register; a result
// waiting on out_stall does not block the next input beat, only the finish of the one after.
// reset returns estimates, covariance and registers to their defaults.
`default_nettype none

module kalman_filter_angle_rate_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire kfar_pkg::word_t               measurement,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output kfar_pkg::word_t                    angle_est,
    output kfar_pkg::word_t                    filtered_rate,
    output logic                               saturated,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kfar_pkg::IDX_W-1:0]    cfg_index,
    input  wire logic [kfar_pkg::W-1:0]        cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_WB, ST_NOISE, ST_SCHK, ST_DIV0, ST_DIV1, ST_FINISH
    } state_t;

    localparam logic [3:0] MOP_PRED_LAST = 4'd3;
    localparam logic [3:0] MOP_UPD_FIRST = 4'd4;
    localparam logic [3:0] MOP_LAST      = 4'd9;

    state_t          state_reg, state_next;
    logic [3:0]      mop_reg, mop_next;
    kfar_pkg::cfg_t  dt_reg, dt_next, q1_reg, q1_next, q2_reg, q2_next, r_reg, r_next;
    kfar_pkg::word_t init_reg, init_next;
    kfar_pkg::word_t ang_reg, ang_next, rate_reg, rate_next;
    kfar_pkg::word_t caa_reg, caa_next, car_reg, car_next;
    kfar_pkg::word_t cra_reg, cra_next, crr_reg, crr_next;
    kfar_pkg::word_t t00_reg, t00_next, t01_reg, t01_next;
    kfar_pkg::word_t p00_reg, p00_next, p10_reg, p10_next, p11_reg, p11_next;
    kfar_pkg::word_t k0_reg, k0_next, k1_reg, k1_next;
    kfar_pkg::word_t err_reg, err_next, z_reg, z_next;
    logic            flag_reg, flag_next;
    logic            ov_reg, ov_next;
    kfar_pkg::word_t oa_reg, oa_next, or_reg, or_next;
    logic            os_reg, os_next;

    kfar_pkg::word_t     mul_a, mul_b;
    kfar_pkg::mul_res_t  mul_res;
    logic                div_start;
    kfar_pkg::word_t     div_num;
    kfar_pkg::div_stat_t div_stat;

    kfar_pkg::wide_t m_x, sum_x, sum_p10, s_x, nq1, nq2, ne;
    logic            s_pos;

    kfar_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .res   (mul_res)
    );

    kfar_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_x[kfar_pkg::W:0]),
        .stat  (div_stat)
    );

    // multiplier operand select
    always_comb
    begin
        case (mop_reg)
            4'd0:    begin mul_a = rate_reg; mul_b = kfar_pkg::word_t'({1'b0, dt_reg}); end
            4'd1:    begin mul_a = cra_reg;  mul_b = kfar_pkg::word_t'({1'b0, dt_reg}); end
            4'd2:    begin mul_a = crr_reg;  mul_b = kfar_pkg::word_t'({1'b0, dt_reg}); end
            4'd3:    begin mul_a = t01_reg;  mul_b = kfar_pkg::word_t'({1'b0, dt_reg}); end
            4'd4:    begin mul_a = k0_reg;   mul_b = err_reg; end
            4'd5:    begin mul_a = k1_reg;   mul_b = err_reg; end
            4'd6:    begin mul_a = k0_reg;   mul_b = p00_reg; end
            4'd7:    begin mul_a = k0_reg;   mul_b = t01_reg; end
            4'd8:    begin mul_a = k1_reg;   mul_b = p00_reg; end
            4'd9:    begin mul_a = k1_reg;   mul_b = t01_reg; end
            default: begin mul_a = '0;       mul_b = '0; end
        endcase
    end

    // write-back sums
    always_comb
    begin
        m_x     = kfar_pkg::ext_s(mul_res.value);
        sum_p10 = kfar_pkg::ext_s(cra_reg) + m_x;
        case (mop_reg)
            4'd0:    sum_x = kfar_pkg::ext_s(ang_reg) + m_x;
            4'd1:    sum_x = kfar_pkg::ext_s(caa_reg) + m_x;
            4'd2:    sum_x = kfar_pkg::ext_s(car_reg) + m_x;
            4'd3:    sum_x = kfar_pkg::ext_s(t00_reg) + m_x;
            4'd4:    sum_x = kfar_pkg::ext_s(ang_reg) + m_x;
            4'd5:    sum_x = kfar_pkg::ext_s(rate_reg) + m_x;
            4'd6:    sum_x = kfar_pkg::ext_s(p00_reg) - m_x;
            4'd7:    sum_x = kfar_pkg::ext_s(t01_reg) - m_x;
            4'd8:    sum_x = kfar_pkg::ext_s(p10_reg) - m_x;
            4'd9:    sum_x = kfar_pkg::ext_s(p11_reg) - m_x;
            default: sum_x = '0;
        endcase
        nq1   = kfar_pkg::ext_s(p00_reg) + kfar_pkg::ext_u(q1_reg);
        nq2   = kfar_pkg::ext_s(crr_reg) + kfar_pkg::ext_u(q2_reg);
        ne    = kfar_pkg::ext_s(z_reg) - kfar_pkg::ext_s(ang_reg);
        s_x   = kfar_pkg::ext_s(p00_reg) + kfar_pkg::ext_u(r_reg);
        s_pos = !s_x[kfar_pkg::WIDE-1] && (s_x != '0);
    end

    assign div_num   = (state_reg == ST_SCHK) ? p00_reg : p10_reg;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        mop_next   = mop_reg;
        dt_next = dt_reg; q1_next = q1_reg; q2_next = q2_reg; r_next = r_reg;
        init_next = init_reg;
        ang_next = ang_reg; rate_next = rate_reg;
        caa_next = caa_reg; car_next = car_reg; cra_next = cra_reg; crr_next = crr_reg;
        t00_next = t00_reg; t01_next = t01_reg;
        p00_next = p00_reg; p10_next = p10_reg; p11_next = p11_reg;
        k0_next = k0_reg; k1_next = k1_reg; err_next = err_reg; z_next = z_reg;
        flag_next = flag_reg;
        ov_next = ov_reg; oa_next = oa_reg; or_next = or_reg; os_next = os_reg;
        div_start = 1'b0;

        // configuration writes
        if (cfg_valid)
        begin
            case (cfg_index)
                kfar_pkg::CFG_STEP_TIME:   dt_next   = cfg_data[kfar_pkg::CFG_W-1:0];
                kfar_pkg::CFG_ANGLE_NOISE: q1_next   = cfg_data[kfar_pkg::CFG_W-1:0];
                kfar_pkg::CFG_RATE_NOISE:  q2_next   = cfg_data[kfar_pkg::CFG_W-1:0];
                kfar_pkg::CFG_MEAS_NOISE:  r_next    = cfg_data[kfar_pkg::CFG_W-1:0];
                kfar_pkg::CFG_INIT_ANGLE:  init_next = cfg_data;
                default: ;
            endcase
        end

        // output beat taken
        if (ov_reg && !out_stall)
            ov_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    z_next    = measurement;
                    flag_next = 1'b0;
                    if (op)
                    begin
                        ang_next   = init_reg;
                        rate_next  = '0;
                        caa_next   = kfar_pkg::ONE_FX;
                        car_next   = '0;
                        cra_next   = '0;
                        crr_next   = kfar_pkg::ONE_FX;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        mop_next   = '0;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                flag_next = flag_reg | mul_res.ovf | kfar_pkg::sat_ovf(sum_x);
                case (mop_reg)
                    4'd0: ang_next = kfar_pkg::sat_word(sum_x);
                    4'd1: t00_next = kfar_pkg::sat_word(sum_x);
                    4'd2:
                    begin
                        t01_next  = kfar_pkg::sat_word(sum_x);
                        p10_next  = kfar_pkg::sat_word(sum_p10);
                        flag_next = flag_reg | mul_res.ovf | kfar_pkg::sat_ovf(sum_x)
                                  | kfar_pkg::sat_ovf(sum_p10);
                    end
                    4'd3: p00_next  = kfar_pkg::sat_word(sum_x);
                    4'd4: ang_next  = kfar_pkg::sat_word(sum_x);
                    4'd5: rate_next = kfar_pkg::sat_word(sum_x);
                    4'd6: caa_next  = kfar_pkg::sat_word(sum_x);
                    4'd7: car_next  = kfar_pkg::sat_word(sum_x);
                    4'd8: cra_next  = kfar_pkg::sat_word(sum_x);
                    4'd9: crr_next  = kfar_pkg::sat_word(sum_x);
                    default: ;
                endcase
                mop_next = mop_reg + 4'd1;
                if (mop_reg == MOP_PRED_LAST)
                    state_next = ST_NOISE;
                else if (mop_reg == MOP_LAST)
                    state_next = ST_FINISH;
                else
                    state_next = ST_MUL;
            end
            ST_NOISE:
            begin
                p00_next   = kfar_pkg::sat_word(nq1);
                p11_next   = kfar_pkg::sat_word(nq2);
                err_next   = kfar_pkg::sat_word(ne);
                flag_next  = flag_reg | kfar_pkg::sat_ovf(nq1) | kfar_pkg::sat_ovf(nq2)
                           | kfar_pkg::sat_ovf(ne);
                state_next = ST_SCHK;
            end
            ST_SCHK:
            begin
                if (s_pos)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV0;
                end
                else
                begin
                    // gain forced to zero
                    flag_next  = 1'b1;
                    k0_next    = '0;
                    k1_next    = '0;
                    mop_next   = MOP_UPD_FIRST;
                    state_next = ST_MUL;
                end
            end
            ST_DIV0:
            begin
                if (div_stat.done)
                begin
                    k0_next    = div_stat.quo;
                    flag_next  = flag_reg | div_stat.ovf;
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (div_stat.done)
                begin
                    k1_next    = div_stat.quo;
                    flag_next  = flag_reg | div_stat.ovf;
                    mop_next   = MOP_UPD_FIRST;
                    state_next = ST_MUL;
                end
            end
            ST_FINISH:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next    = 1'b1;
                    oa_next    = ang_reg;
                    or_next    = rate_reg;
                    os_next    = flag_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state, estimates, registers and output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mop_reg   <= '0;
            dt_reg    <= kfar_pkg::cfg_t'(16777);
            q1_reg    <= kfar_pkg::cfg_t'(1678);
            q2_reg    <= kfar_pkg::cfg_t'(33554);
            r_reg     <= kfar_pkg::cfg_t'(1678);
            init_reg  <= '0;
            ang_reg   <= '0;
            rate_reg  <= '0;
            caa_reg   <= kfar_pkg::ONE_FX;
            car_reg   <= '0;
            cra_reg   <= '0;
            crr_reg   <= kfar_pkg::ONE_FX;
            t00_reg   <= '0;
            t01_reg   <= '0;
            p00_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= '0;
            k0_reg    <= '0;
            k1_reg    <= '0;
            err_reg   <= '0;
            z_reg     <= '0;
            flag_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            oa_reg    <= '0;
            or_reg    <= '0;
            os_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mop_reg   <= mop_next;
            dt_reg    <= dt_next;
            q1_reg    <= q1_next;
            q2_reg    <= q2_next;
            r_reg     <= r_next;
            init_reg  <= init_next;
            ang_reg   <= ang_next;
            rate_reg  <= rate_next;
            caa_reg   <= caa_next;
            car_reg   <= car_next;
            cra_reg   <= cra_next;
            crr_reg   <= crr_next;
            t00_reg   <= t00_next;
            t01_reg   <= t01_next;
            p00_reg   <= p00_next;
            p10_reg   <= p10_next;
            p11_reg   <= p11_next;
            k0_reg    <= k0_next;
            k1_reg    <= k1_next;
            err_reg   <= err_next;
            z_reg     <= z_next;
            flag_reg  <= flag_next;
            ov_reg    <= ov_next;
            oa_reg    <= oa_next;
            or_reg    <= or_next;
            os_reg    <= os_next;
        end
    end

    assign out_valid      = ov_reg;
    assign angle_est      = oa_reg;
    assign filtered_rate  = or_reg;
    assign saturated      = os_reg;

    // accepted beat leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start work");

    // divider completes only while a gain is awaited
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV0 || state_reg == ST_DIV1))
        else $error("divider result with no gain pending");

    // multiplier op index stays within the schedule
    a_mop_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL || state_reg == ST_WB) |-> (mop_reg <= MOP_LAST))
        else $error("multiplier op index out of range");

    // a new result appears only from the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_FINISH))
        else $error("output beat raised outside finish");

endmodule

`default_nettype wire
